### hdl/seven_segment_frame_builder_defines.svh
// ---------------------------------------------------------------------------
// Seven-segment frame builder: assertion macros
// Shared helpers for the concurrent checks on the block ports.
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_FRAME_BUILDER_DEFINES_SVH
`define SEVEN_SEGMENT_FRAME_BUILDER_DEFINES_SVH

// check that is switched off while reset is held
`define SSFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define SSFB_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ssfb_pkg.sv
// ---------------------------------------------------------------------------
// ssfb_pkg
// Types, command bytes and glyph tables of the seven-segment frame builder.
// ---------------------------------------------------------------------------
`default_nettype none

package ssfb_pkg;

    // request kinds
    typedef enum logic [1:0] {
        FUNC_DECIMAL = 2'd0,
        FUNC_TEXT    = 2'd1,
        FUNC_SINGLE  = 2'd2,
        FUNC_BRIGHT  = 2'd3
    } t_func;

    // command bytes of the driver chip
    localparam logic [7:0] CMD_AUTO_INC = 8'h40;
    localparam logic [7:0] ADDR_FIRST   = 8'hC0;
    localparam logic [7:0] CMD_FIXED    = 8'h44;
    localparam logic [7:0] CMD_CTRL     = 8'h87;
    localparam logic [7:0] SEP_BIT      = 8'h80;
    localparam logic [3:0] BRIGHT_MAX   = 4'd8;

    // bytes per frame group
    localparam logic [2:0] LEN_FOUR   = 3'd6;
    localparam logic [2:0] LEN_SINGLE = 3'd3;
    localparam logic [2:0] LEN_BRIGHT = 3'd1;

    // quotient by ten: exact for every 14-bit x
    function automatic logic [10:0] div10(input logic [13:0] x);
        logic [29:0] p;
        p = {16'b0, x} * 30'd52429;
        return p[29:19];
    endfunction

    // remainder by ten from a known quotient
    function automatic logic [3:0] rem10(input logic [13:0] x, input logic [10:0] q);
        logic [13:0] m;
        logic [13:0] r;
        m = {3'b0, q} * 14'd10;
        r = x - m;
        return r[3:0];
    endfunction

    // decimal digit to segments
    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        unique case (d)
            4'd0:    g = 8'h3f;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5b;
            4'd3:    g = 8'h4f;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6d;
            4'd6:    g = 8'h7d;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7f;
            4'd9:    g = 8'h6f;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // ASCII to segments, blank where no glyph exists
    function automatic logic [7:0] char_glyph(input logic [7:0] ch);
        logic [7:0] g;
        unique case (ch)
            8'h5f:         g = 8'h08; // underscore
            8'h5e:         g = 8'h01; // caret
            8'h2d:         g = 8'h40; // dash
            8'h2a:         g = 8'h63; // star, shown as degree
            8'h41:         g = 8'h77;
            8'h61:         g = 8'h5f;
            8'h42, 8'h62:  g = 8'h7c;
            8'h43:         g = 8'h39;
            8'h63:         g = 8'h58;
            8'h44, 8'h64:  g = 8'h5e;
            8'h45, 8'h65:  g = 8'h79;
            8'h46, 8'h66:  g = 8'h71;
            8'h47, 8'h67:  g = 8'h7d;
            8'h48:         g = 8'h76;
            8'h68:         g = 8'h74;
            8'h49:         g = 8'h06;
            8'h69:         g = 8'h04;
            8'h4a:         g = 8'h1e;
            8'h6a:         g = 8'h16;
            8'h4b, 8'h6b:  g = 8'h75;
            8'h4c, 8'h6c:  g = 8'h38;
            8'h4d, 8'h6d:  g = 8'h37;
            8'h4e, 8'h6e:  g = 8'h54;
            8'h4f, 8'h6f:  g = 8'h5c;
            8'h50, 8'h70:  g = 8'h73;
            8'h51:         g = 8'h7b;
            8'h71:         g = 8'h67;
            8'h52, 8'h72:  g = 8'h50;
            8'h53, 8'h73:  g = 8'h6d;
            8'h54, 8'h74:  g = 8'h78;
            8'h55, 8'h75:  g = 8'h1c;
            8'h56, 8'h76:  g = 8'h3e;
            8'h57:         g = 8'h7e;
            8'h77:         g = 8'h2a;
            8'h58, 8'h78:  g = 8'h76;
            8'h59, 8'h79:  g = 8'h6e;
            8'h5a, 8'h7a:  g = 8'h1b;
            default:       g = 8'h00; // space and everything else
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

### hdl/ssfb_if.sv
// ---------------------------------------------------------------------------
// ssfb_if
// Valid/ready channels: display requests in, link bytes out.
// ---------------------------------------------------------------------------
`default_nettype none

// request channel
interface ssfb_req_if import ssfb_pkg::*; ();
    logic        valid;
    logic        ready;
    t_func       func;
    logic [13:0] number;
    logic        separator;
    logic [7:0]  char_first;
    logic [7:0]  char_second;
    logic [7:0]  char_third;
    logic [7:0]  char_fourth;
    logic [7:0]  position_address;
    logic [7:0]  segment_pattern;

    modport source (
        output valid, func, number, separator, char_first, char_second,
               char_third, char_fourth, position_address, segment_pattern,
        input  ready
    );
    modport sink (
        input  valid, func, number, separator, char_first, char_second,
               char_third, char_fourth, position_address, segment_pattern,
        output ready
    );
endinterface

// link byte channel
interface ssfb_rsp_if ();
    logic       valid;
    logic       ready;
    logic [7:0] link_byte;
    logic       frame_start;
    logic       frame_stop;
    logic       last;

    modport source (
        output valid, link_byte, frame_start, frame_stop, last,
        input  ready
    );
    modport sink (
        input  valid, link_byte, frame_start, frame_stop, last,
        output ready
    );
endinterface

`default_nettype wire

### hdl/seven_segment_frame_builder.sv
// ---------------------------------------------------------------------------
// seven_segment_frame_builder
// Turns display requests into tagged link bytes for a four-digit driver.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries one request per beat (decimal, text, single position or
//   brightness). o_rsp carries one link byte per beat with its start/stop
//   tags; last marks the final byte of a request. i_cfg_we/i_cfg_wdata load
//   the brightness register, to be written only while the block is idle.
//   Pipeline: input register, first digit split, second digit split, then a
//   frame shift register that holds up to six bytes. A request passes
//   through these in order before its first byte is shown. The output
//   port sets the throughput at one byte per cycle while the receiver is
//   ready; a decimal or text request is six bytes, single position three,
//   brightness one. Up to three requests wait in stages as a frame drains.
//   Reset clears all valid flags and the brightness register (display off).
//   When the receiver stalls, the current byte holds and the stages fill
//   up; i_req.ready drops only once every stage is occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module seven_segment_frame_builder import ssfb_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [3:0]  i_cfg_wdata,
    ssfb_req_if.sink   i_req,
    ssfb_rsp_if.source o_rsp
);

    // brightness register
    logic [3:0] r_bright;

    // stage A: registered request
    logic        r_a_valid;
    t_func       r_a_func;
    logic [13:0] r_a_number;
    logic        r_a_sep;
    logic [3:0][7:0] r_a_char;
    logic [7:0]  r_a_addr;
    logic [7:0]  r_a_pat;

    // stage B: units digit done, text glyphs mapped
    logic        r_b_valid;
    t_func       r_b_func;
    logic [10:0] r_b_q;
    logic        r_b_sep;
    logic [3:0][7:0] r_b_seg;
    logic [7:0]  r_b_addr;
    logic [7:0]  r_b_pat;

    // stage C: tens digit done
    logic        r_c_valid;
    t_func       r_c_func;
    logic [7:0]  r_c_q;
    logic        r_c_sep;
    logic [3:0][7:0] r_c_seg;
    logic [7:0]  r_c_addr;
    logic [7:0]  r_c_pat;

    // frame shift register
    logic [2:0]  r_s_left;
    logic [7:0]  r_s_byte  [6];
    logic        r_s_start [6];
    logic        r_s_stop  [6];

    logic        s_free, c_ready, b_ready, a_ready;
    logic        out_fire;

    logic [10:0] n_b_q;
    logic [3:0]  n_b_r;
    logic [3:0][7:0] n_b_seg;
    logic [10:0] n_c_q;
    logic [3:0]  n_c_r;
    logic [3:0][7:0] n_c_seg;
    logic [10:0] s_q3;
    logic [3:0]  s_r2;
    logic [3:0]  s_d0;
    logic [3:0][7:0] s_seg;
    logic [3:0]  s_bright;
    logic [2:0]  n_s_left;
    logic [7:0]  n_s_byte  [6];
    logic        n_s_start [6];
    logic        n_s_stop  [6];

    // elastic pipeline control
    assign out_fire    = o_rsp.valid && o_rsp.ready;
    assign s_free      = (r_s_left == 3'd0) || ((r_s_left == 3'd1) && o_rsp.ready);
    assign c_ready     = !r_c_valid || s_free;
    assign b_ready     = !r_b_valid || c_ready;
    assign a_ready     = !r_a_valid || b_ready;
    assign i_req.ready = a_ready;

    // brightness register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= 4'd0;
        end else if (i_cfg_we) begin
            r_bright <= i_cfg_wdata;
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_req.valid) begin
            r_a_func    <= i_req.func;
            r_a_number  <= i_req.number;
            r_a_sep     <= i_req.separator;
            r_a_char[0] <= i_req.char_first;
            r_a_char[1] <= i_req.char_second;
            r_a_char[2] <= i_req.char_third;
            r_a_char[3] <= i_req.char_fourth;
            r_a_addr    <= i_req.position_address;
            r_a_pat     <= i_req.segment_pattern;
        end
    end

    // A to B: units digit, glyph lookup for text
    always_comb begin
        n_b_q = div10(r_a_number);
        n_b_r = rem10(r_a_number, n_b_q);
        for (int k = 0; k < 4; k++) begin
            n_b_seg[k] = char_glyph(r_a_char[k]);
        end
        if (r_a_func == FUNC_DECIMAL) begin
            n_b_seg[3] = digit_glyph(n_b_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_func <= r_a_func;
            r_b_q    <= n_b_q;
            r_b_sep  <= r_a_sep;
            r_b_seg  <= n_b_seg;
            r_b_addr <= r_a_addr;
            r_b_pat  <= r_a_pat;
        end
    end

    // B to C: tens digit
    always_comb begin
        n_c_q   = div10({3'b0, r_b_q});
        n_c_r   = rem10({3'b0, r_b_q}, n_c_q);
        n_c_seg = r_b_seg;
        if (r_b_func == FUNC_DECIMAL) begin
            n_c_seg[2] = digit_glyph(n_c_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_c_func <= r_b_func;
            r_c_q    <= n_c_q[7:0];
            r_c_sep  <= r_b_sep;
            r_c_seg  <= n_c_seg;
            r_c_addr <= r_b_addr;
            r_c_pat  <= r_b_pat;
        end
    end

    // C to frame: hundreds and thousands digits, then frame assembly
    always_comb begin
        s_q3  = div10({6'b0, r_c_q});
        s_r2  = rem10({6'b0, r_c_q}, s_q3);
        // thousands digit wraps above 9999
        s_d0  = (s_q3[4:0] >= 5'd10) ? 4'(s_q3[4:0] - 5'd10) : s_q3[3:0];
        s_seg = r_c_seg;
        if (r_c_func == FUNC_DECIMAL) begin
            s_seg[1] = digit_glyph(s_r2) | (r_c_sep ? SEP_BIT : 8'h00);
            s_seg[0] = digit_glyph(s_d0);
        end
        s_bright = (r_bright > BRIGHT_MAX) ? BRIGHT_MAX : r_bright;

        for (int k = 0; k < 6; k++) begin
            n_s_byte[k]  = 8'h00;
            n_s_start[k] = 1'b0;
            n_s_stop[k]  = 1'b0;
        end
        unique case (r_c_func)
            FUNC_DECIMAL, FUNC_TEXT: begin
                n_s_left     = LEN_FOUR;
                n_s_byte[0]  = CMD_AUTO_INC;
                n_s_start[0] = 1'b1;
                n_s_stop[0]  = 1'b1;
                n_s_byte[1]  = ADDR_FIRST;
                n_s_start[1] = 1'b1;
                n_s_byte[2]  = s_seg[0];
                n_s_byte[3]  = s_seg[1];
                n_s_byte[4]  = s_seg[2];
                n_s_byte[5]  = s_seg[3];
                n_s_stop[5]  = 1'b1;
            end
            FUNC_SINGLE: begin
                n_s_left     = LEN_SINGLE;
                n_s_byte[0]  = CMD_FIXED;
                n_s_start[0] = 1'b1;
                n_s_stop[0]  = 1'b1;
                n_s_byte[1]  = r_c_addr;
                n_s_start[1] = 1'b1;
                n_s_byte[2]  = r_c_pat;
                n_s_stop[2]  = 1'b1;
            end
            FUNC_BRIGHT: begin
                n_s_left     = LEN_BRIGHT;
                n_s_byte[0]  = CMD_CTRL + {4'b0, s_bright};
                n_s_start[0] = 1'b1;
                n_s_stop[0]  = 1'b1;
            end
        endcase
    end

    // frame shift register: load a new frame or shift one byte out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_left <= 3'd0;
        end else if (r_c_valid && s_free) begin
            r_s_left <= n_s_left;
        end else if (out_fire) begin
            r_s_left <= r_s_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid && s_free) begin
            r_s_byte  <= n_s_byte;
            r_s_start <= n_s_start;
            r_s_stop  <= n_s_stop;
        end else if (out_fire) begin
            for (int k = 0; k < 5; k++) begin
                r_s_byte[k]  <= r_s_byte[k+1];
                r_s_start[k] <= r_s_start[k+1];
                r_s_stop[k]  <= r_s_stop[k+1];
            end
        end
    end

    // output beat
    assign o_rsp.valid       = (r_s_left != 3'd0);
    assign o_rsp.link_byte   = r_s_byte[0];
    assign o_rsp.frame_start = r_s_start[0];
    assign o_rsp.frame_stop  = r_s_stop[0];
    assign o_rsp.last        = (r_s_left == 3'd1);

endmodule

`default_nettype wire

### hdl/ssfb_chk.sv
// ---------------------------------------------------------------------------
// ssfb_chk
// Port-level checks on the link byte channel of the frame builder.
// ---------------------------------------------------------------------------
`default_nettype none

`include "seven_segment_frame_builder_defines.svh"

module ssfb_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_link_byte,
    input wire       i_frame_start,
    input wire       i_frame_stop,
    input wire       i_last
);

    // no beat right after reset
    `SSFB_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "beat shown after reset")

    // bytes of one request leave without gaps
    `SSFB_ASSERT(a_frame_gapless, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last |=> i_out_valid, "gap inside a request")

    // a request always ends on a stop condition
    `SSFB_ASSERT(a_last_stops, i_clk, i_rst_n, i_out_valid && i_last |-> i_frame_stop, "last byte without stop")

    // the byte after a request's last opens a new frame
    `SSFB_ASSERT(a_next_starts, i_clk, i_rst_n, i_out_valid && i_out_ready && i_last |=> !i_out_valid || i_frame_start, "request begins without start")

    // a stalled beat holds its byte
    `SSFB_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_link_byte), "stalled byte changed")

endmodule

bind seven_segment_frame_builder ssfb_chk u_ssfb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_link_byte   (o_rsp.link_byte),
    .i_frame_start (o_rsp.frame_start),
    .i_frame_stop  (o_rsp.frame_stop),
    .i_last        (o_rsp.last)
);

`default_nettype wire

### test/seven_segment_frame_builder_test.sv
// ---------------------------------------------------------------------------
// seven_segment_frame_builder_test
// Self-checking bench: requests go in through a valid/ready driver, link
// bytes are checked beat by beat against a frame predictor, across several
// brightness settings, with random idling on both sides and one long
// receiver hold-off that backs the block up.
// ---------------------------------------------------------------------------
`default_nettype none

module seven_segment_frame_builder_test import ssfb_pkg::*;;

    // driver chip command bytes, kept apart from the design's own copies
    localparam logic [7:0] AUTO_INC_CMD = 8'h40;
    localparam logic [7:0] FIRST_ADDR   = 8'hc0;
    localparam logic [7:0] FIXED_CMD    = 8'h44;
    localparam logic [7:0] CTRL_BASE    = 8'h87;
    localparam logic [7:0] DOT_BIT      = 8'h80;
    localparam logic [3:0] TOP_LEVEL    = 4'd8;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_CYCLES  = 400;

    typedef struct packed {
        t_func       func;
        logic [13:0] number;
        logic        separator;
        logic [7:0]  char_first;
        logic [7:0]  char_second;
        logic [7:0]  char_third;
        logic [7:0]  char_fourth;
        logic [7:0]  position_address;
        logic [7:0]  segment_pattern;
    } t_disp_req;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       stop;
        logic       last;
    } t_link_beat;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       cfg_we      = 1'b0;
    logic [3:0] cfg_wdata   = 4'd0;
    logic       drv_valid   = 1'b0;
    t_disp_req  drv_req     = '0;
    logic       rx_ready    = 1'b0;

    t_disp_req  pending_reqs[$];
    t_link_beat link_beats_due[$];
    logic [3:0] bright_now  = 4'd0;
    bit         idle_en     = 1'b1;
    bit         hold_arm    = 1'b0;
    bit         hold_used   = 1'b0;
    int         hold_left   = 0;
    int         tx_gap      = 0;
    int         rx_gap      = 0;
    int         beat_no     = 0;
    int         err_count   = 0;
    int         cycle_count = 0;
    t_link_beat mon_want;

    ssfb_req_if req_ch ();
    ssfb_rsp_if rsp_ch ();

    assign req_ch.valid            = drv_valid;
    assign req_ch.func             = drv_req.func;
    assign req_ch.number           = drv_req.number;
    assign req_ch.separator        = drv_req.separator;
    assign req_ch.char_first       = drv_req.char_first;
    assign req_ch.char_second      = drv_req.char_second;
    assign req_ch.char_third       = drv_req.char_third;
    assign req_ch.char_fourth      = drv_req.char_fourth;
    assign req_ch.position_address = drv_req.position_address;
    assign req_ch.segment_pattern  = drv_req.segment_pattern;
    assign rsp_ch.ready            = rx_ready;

    seven_segment_frame_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // clock, period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // segments of a decimal digit
    function automatic logic [7:0] digit_seg(input int d);
        case (d)
            0: return 8'h3f;
            1: return 8'h06;
            2: return 8'h5b;
            3: return 8'h4f;
            4: return 8'h66;
            5: return 8'h6d;
            6: return 8'h7d;
            7: return 8'h07;
            8: return 8'h7f;
            default: return 8'h6f;
        endcase
    endfunction

    // segments of a character; anything without a glyph is blank
    function automatic logic [7:0] char_seg(input logic [7:0] ch);
        case (ch)
            "_":      return 8'h08;
            "^":      return 8'h01;
            "-":      return 8'h40;
            "*":      return 8'h63;
            "A":      return 8'h77;
            "a":      return 8'h5f;
            "B", "b": return 8'h7c;
            "C":      return 8'h39;
            "c":      return 8'h58;
            "D", "d": return 8'h5e;
            "E", "e": return 8'h79;
            "F", "f": return 8'h71;
            "G", "g": return 8'h7d;
            "H":      return 8'h76;
            "h":      return 8'h74;
            "I":      return 8'h06;
            "i":      return 8'h04;
            "J":      return 8'h1e;
            "j":      return 8'h16;
            "K", "k": return 8'h75;
            "L", "l": return 8'h38;
            "M", "m": return 8'h37;
            "N", "n": return 8'h54;
            "O", "o": return 8'h5c;
            "P", "p": return 8'h73;
            "Q":      return 8'h7b;
            "q":      return 8'h67;
            "R", "r": return 8'h50;
            "S", "s": return 8'h6d;
            "T", "t": return 8'h78;
            "U", "u": return 8'h1c;
            "V", "v": return 8'h3e;
            "W":      return 8'h7e;
            "w":      return 8'h2a;
            "X", "x": return 8'h76;
            "Y", "y": return 8'h6e;
            "Z", "z": return 8'h1b;
            default:  return 8'h00;
        endcase
    endfunction

    // auto-increment frame: command, first address, four digits
    task automatic push_four(input logic [7:0] s0, s1, s2, s3);
        link_beats_due.push_back(t_link_beat'{AUTO_INC_CMD, 1'b1, 1'b1, 1'b0});
        link_beats_due.push_back(t_link_beat'{FIRST_ADDR, 1'b1, 1'b0, 1'b0});
        link_beats_due.push_back(t_link_beat'{s0, 1'b0, 1'b0, 1'b0});
        link_beats_due.push_back(t_link_beat'{s1, 1'b0, 1'b0, 1'b0});
        link_beats_due.push_back(t_link_beat'{s2, 1'b0, 1'b0, 1'b0});
        link_beats_due.push_back(t_link_beat'{s3, 1'b0, 1'b1, 1'b1});
    endtask

    // link bytes that one accepted request must produce
    task automatic queue_frame(input t_disp_req r);
        int         v;
        logic [7:0] hund;
        logic [3:0] lvl;
        case (r.func)
            FUNC_DECIMAL: begin
                v = int'(r.number) % 10000;
                hund = digit_seg((v / 100) % 10);
                if (r.separator) begin
                    hund = hund | DOT_BIT;
                end
                push_four(digit_seg(v / 1000), hund, digit_seg((v / 10) % 10),
                          digit_seg(v % 10));
            end
            FUNC_TEXT: begin
                push_four(char_seg(r.char_first), char_seg(r.char_second),
                          char_seg(r.char_third), char_seg(r.char_fourth));
            end
            FUNC_SINGLE: begin
                link_beats_due.push_back(t_link_beat'{FIXED_CMD, 1'b1, 1'b1, 1'b0});
                link_beats_due.push_back(
                    t_link_beat'{r.position_address, 1'b1, 1'b0, 1'b0});
                link_beats_due.push_back(
                    t_link_beat'{r.segment_pattern, 1'b0, 1'b1, 1'b1});
            end
            default: begin
                // levels above the top clamp to the top
                lvl = (bright_now > TOP_LEVEL) ? TOP_LEVEL : bright_now;
                link_beats_due.push_back(
                    t_link_beat'{CTRL_BASE + {4'd0, lvl}, 1'b1, 1'b1, 1'b1});
            end
        endcase
    endtask

    task automatic flag_error(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // driver: one request per beat, random gaps between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            tx_gap    <= 0;
        end else begin
            if (drv_valid && req_ch.ready) begin
                queue_frame(drv_req);
            end
            if (!drv_valid || req_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap    <= tx_gap - 1;
                    drv_valid <= 1'b0;
                end else if (idle_en && pending_reqs.size() != 0 &&
                             $urandom_range(0, 3) == 0) begin
                    tx_gap    <= $urandom_range(0, 14);
                    drv_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    drv_req   <= pending_reqs.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, armed once
    always @(posedge i_clk) begin
        if (hold_arm && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: check each link beat, then pick the next ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            rx_gap   <= 0;
        end else begin
            if (rx_ready && rsp_ch.valid) begin
                if (link_beats_due.size() == 0) begin
                    flag_error($sformatf("beat %0d: link byte %h with none due",
                                         beat_no, rsp_ch.link_byte));
                end else begin
                    mon_want = link_beats_due.pop_front();
                    if (rsp_ch.link_byte !== mon_want.data)
                        flag_error($sformatf("beat %0d: link_byte %h, want %h",
                                             beat_no, rsp_ch.link_byte, mon_want.data));
                    if (rsp_ch.frame_start !== mon_want.start)
                        flag_error($sformatf("beat %0d: frame_start %b, want %b",
                                             beat_no, rsp_ch.frame_start, mon_want.start));
                    if (rsp_ch.frame_stop !== mon_want.stop)
                        flag_error($sformatf("beat %0d: frame_stop %b, want %b",
                                             beat_no, rsp_ch.frame_stop, mon_want.stop));
                    if (rsp_ch.last !== mon_want.last)
                        flag_error($sformatf("beat %0d: last %b, want %b",
                                             beat_no, rsp_ch.last, mon_want.last));
                end
                beat_no++;
            end
            if (hold_left > 0) begin
                rx_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap   <= rx_gap - 1;
                rx_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                rx_gap   <= $urandom_range(0, 14);
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_req(input t_func f, input logic [13:0] num, input logic sep,
                           input logic [31:0] chars, input logic [7:0] addr,
                           input logic [7:0] seg);
        t_disp_req r;
        r.func             = f;
        r.number           = num;
        r.separator        = sep;
        r.char_first       = chars[31:24];
        r.char_second      = chars[23:16];
        r.char_third       = chars[15:8];
        r.char_fourth      = chars[7:0];
        r.position_address = addr;
        r.segment_pattern  = seg;
        pending_reqs.push_back(r);
    endtask

    // mostly printable, sometimes any code at all
    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(32, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_disp_req rand_req();
        t_disp_req r;
        r.func = t_func'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0)
            r.number = 14'($urandom_range(10000, 16383));
        else
            r.number = 14'($urandom_range(0, 9999));
        r.separator   = 1'($urandom_range(0, 1));
        r.char_first  = rand_char();
        r.char_second = rand_char();
        r.char_third  = rand_char();
        r.char_fourth = rand_char();
        if ($urandom_range(0, 3) != 0)
            r.position_address = FIRST_ADDR + 8'($urandom_range(0, 3));
        else
            r.position_address = 8'($urandom_range(0, 255));
        r.segment_pattern = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // wait until every request is in and every byte is out
    task automatic settle();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || drv_valid || link_beats_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_brightness(input logic [3:0] v);
        @(posedge i_clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        bright_now  = v;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        @(negedge i_clk);
    endtask

    // sequence: reset, directed frames, then one random batch per setting
    initial begin
        logic [3:0] plan [8];
        bit         calm [8];
        plan = '{4'd8, 4'd15, 4'd1, 4'd9, 4'd0, 4'd0, 4'd3, 4'd8};
        calm = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
        plan[5] = 4'($urandom_range(0, 15));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_brightness(4'd0);

        // digit extremes, separator, values past four digits
        add_req(FUNC_DECIMAL, 14'd0,     1'b0, "0000", 8'h00, 8'h00);
        add_req(FUNC_DECIMAL, 14'd9999,  1'b1, "9999", 8'hff, 8'hff);
        add_req(FUNC_DECIMAL, 14'd1234,  1'b1, "1234", 8'hc0, 8'h12);
        add_req(FUNC_DECIMAL, 14'd5678,  1'b0, "5678", 8'hc1, 8'h34);
        add_req(FUNC_DECIMAL, 14'd10000, 1'b0, "----", 8'hc2, 8'h56);
        add_req(FUNC_DECIMAL, 14'd16383, 1'b1, "zzzz", 8'hc3, 8'h78);
        // glyphs, symbols, blank and codes with no glyph
        add_req(FUNC_TEXT,    14'd0,     1'b1, "ABCD", 8'h00, 8'h00);
        add_req(FUNC_TEXT,    14'd9999,  1'b0, "abcd", 8'h00, 8'h00);
        add_req(FUNC_TEXT,    14'd0,     1'b0, " _^-", 8'h00, 8'h00);
        add_req(FUNC_TEXT,    14'd0,     1'b0, "*Hhw", 8'h00, 8'h00);
        add_req(FUNC_TEXT,    14'd16383, 1'b1, 32'h80ff007f, 8'hff, 8'hff);
        add_req(FUNC_TEXT,    14'd0,     1'b0, "Zq9!", 8'h00, 8'h00);
        // in-range and out-of-range addresses, raw pattern extremes
        add_req(FUNC_SINGLE,  14'd0,     1'b0, "    ", 8'hc0, 8'h00);
        add_req(FUNC_SINGLE,  14'd16383, 1'b1, 32'hffffffff, 8'hc3, 8'hff);
        add_req(FUNC_SINGLE,  14'd0,     1'b0, "    ", 8'h00, 8'h55);
        add_req(FUNC_SINGLE,  14'd0,     1'b0, "    ", 8'hff, 8'haa);
        add_req(FUNC_BRIGHT,  14'd0,     1'b0, "    ", 8'h00, 8'h00);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            idle_en = !calm[ph];
            write_brightness(plan[ph]);
            add_req(FUNC_BRIGHT, 14'd16383, 1'b1, "BBBB", 8'hff, 8'hff);
            if (ph == 2) begin
                // receiver holds off while requests keep coming
                repeat (30) pending_reqs.push_back(rand_req());
                hold_arm = 1'b1;
            end
            repeat (54) pending_reqs.push_back(rand_req());
            settle();
        end

        if (link_beats_due.size() != 0)
            flag_error($sformatf("%0d link bytes never arrived", link_beats_due.size()));
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
